// ===== rtl/imufsa_pkg.sv =====
package imufsa_pkg;

   // timeslot table geometry
   localparam int SLOT_COUNT = 4;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);

   // output queue geometry
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // sensor tags in tag bits 7:3
   localparam logic [4:0] TAG_GYRO  = 5'h01;
   localparam logic [4:0] TAG_ACCEL = 5'h02;
   localparam logic [4:0] TAG_TIME  = 5'h04;

   // fixed point of the tick period
   localparam int Q_SHIFT = 16;
   localparam int PROD_W  = 56;

   // configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_HOST_TIME_BASE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_TIME_BASE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_GAIN       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_GAIN        = 3'd4;

   localparam logic [23:0] TICK_PERIOD_RST = 24'd1638400;
   localparam logic [15:0] GAIN_RST        = 16'd1;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [1:0]        kind_type;
   typedef logic [2:0][31:0]  vec_type;

   // decoded word kind
   localparam kind_type KIND_NONE  = 2'd0;
   localparam kind_type KIND_GYRO  = 2'd1;
   localparam kind_type KIND_ACCEL = 2'd2;
   localparam kind_type KIND_TIME  = 2'd3;

   // word at the commit stage
   typedef struct packed {
      logic              vld;
      kind_type          kind;
      slot_type          slot;
      logic              batch;
      vec_type           vec;
      logic [PROD_W-1:0] prod;
   } item_type;

   // slot contents as read for the commit stage
   typedef struct packed {
      logic [63:0] tstamp;
      vec_type     accel;
      vec_type     gyro;
   } slot_rd_type;

   // slot write from the commit stage
   typedef struct packed {
      logic        time_we;
      logic        accel_we;
      logic        gyro_we;
      slot_type    slot;
      logic [63:0] tstamp;
      vec_type     vec;
   } slot_wr_type;

   typedef struct packed {
      logic [63:0] tstamp;
      vec_type     accel;
      vec_type     gyro;
   } sample_type;

   function automatic kind_type decode_kind(input logic [7:0] tag);
      kind_type k;
      k = KIND_NONE;
      if (tag[7:3] == TAG_GYRO) begin
         k = KIND_GYRO;
      end else if (tag[7:3] == TAG_ACCEL) begin
         k = KIND_ACCEL;
      end else if (tag[7:3] == TAG_TIME) begin
         k = KIND_TIME;
      end
      return k;
   endfunction

   // signed count times unsigned gain, low 32 bits kept
   function automatic logic [31:0] scale_count(input logic [15:0] w, input logic [15:0] g);
      logic signed [32:0] p;
      p = $signed(w) * $signed({1'b0, g});
      return p[31:0];
   endfunction

endpackage

// ===== rtl/imufsa_front.sv =====
module imufsa_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    accept,
   input  logic                    batch_start,
   input  logic [7:0]              tag_byte,
   input  logic [15:0]             word_x,
   input  logic [15:0]             word_y,
   input  logic [15:0]             word_z,
   input  logic [31:0]             sensor_time_base,
   input  logic [23:0]             tick_period_q16,
   input  logic [15:0]             accel_gain,
   input  logic [15:0]             gyro_gain,
   output imufsa_pkg::item_type    item
);
   import imufsa_pkg::*;

   logic             s1_vld_ff, s1_vld_in;
   kind_type         s1_kind_ff;
   slot_type         s1_slot_ff;
   logic             s1_batch_ff;
   logic [2:0][15:0] s1_words_ff;
   logic [31:0]      s1_delta_ff, s1_delta_in;

   item_type         s2_ff, s2_in;
   logic [15:0]      gain;

   // tick delta modulo 2^32
   assign s1_delta_in = {word_y, word_x} - sensor_time_base;
   assign s1_vld_in   = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff  <= decode_kind(tag_byte);
         s1_slot_ff  <= tag_byte[SLOT_W:1];
         s1_batch_ff <= batch_start;
         s1_words_ff <= {word_z, word_y, word_x};
         s1_delta_ff <= s1_delta_in;
      end
   end

   assign gain = (s1_kind_ff == KIND_GYRO) ? gyro_gain : accel_gain;

   always_comb begin
      s2_in        = '0;
      s2_in.vld    = s1_vld_ff;
      s2_in.kind   = s1_kind_ff;
      s2_in.slot   = s1_slot_ff;
      s2_in.batch  = s1_batch_ff;
      for (int k = 0; k < 3; k++) begin
         s2_in.vec[k] = scale_count(s1_words_ff[k], gain);
      end
      s2_in.prod = {24'd0, s1_delta_ff} * {32'd0, tick_period_q16};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.vld <= 1'b0;
      end else if (adv) begin
         s2_ff.vld <= s2_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff.kind  <= s2_in.kind;
         s2_ff.slot  <= s2_in.slot;
         s2_ff.batch <= s2_in.batch;
         s2_ff.vec   <= s2_in.vec;
         s2_ff.prod  <= s2_in.prod;
      end
   end

   assign item = s2_ff;

endmodule

// ===== rtl/imufsa_slot_store.sv =====
module imufsa_slot_store (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  imufsa_pkg::slot_type     rd_slot,
   input  imufsa_pkg::slot_wr_type  wr,
   output imufsa_pkg::slot_rd_type  rd
);
   import imufsa_pkg::*;

   logic [63:0]  time_mem [SLOT_COUNT];
   logic [191:0] vec_mem  [SLOT_COUNT];

   logic [63:0]  rd_time_ff;
   logic [191:0] rd_vec_ff;
   slot_type     rd_slot_ff;

   slot_wr_type  lw_ff;
   slot_rd_type  merged, out_ff;

   // memories: one write address, one read address, registered read
   always_ff @(posedge clock) begin
      if (adv) begin
         if (wr.time_we) begin
            time_mem[wr.slot] <= wr.tstamp;
         end
         if (wr.accel_we) begin
            vec_mem[wr.slot][191:96] <= wr.vec;
         end
         if (wr.gyro_we) begin
            vec_mem[wr.slot][95:0] <= wr.vec;
         end
         rd_time_ff <= time_mem[rd_slot];
         rd_vec_ff  <= vec_mem[rd_slot];
         rd_slot_ff <= rd_slot;
      end
   end

   // write that landed on the same edge as the read
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff <= '0;
      end else if (adv) begin
         lw_ff <= wr;
      end
   end

   // forwarding: the write in flight wins over the older one
   always_comb begin
      merged.tstamp = rd_time_ff;
      merged.accel  = rd_vec_ff[191:96];
      merged.gyro   = rd_vec_ff[95:0];
      if (lw_ff.slot == rd_slot_ff) begin
         if (lw_ff.time_we) begin
            merged.tstamp = lw_ff.tstamp;
         end
         if (lw_ff.accel_we) begin
            merged.accel = lw_ff.vec;
         end
         if (lw_ff.gyro_we) begin
            merged.gyro = lw_ff.vec;
         end
      end
      if (wr.slot == rd_slot_ff) begin
         if (wr.time_we) begin
            merged.tstamp = wr.tstamp;
         end
         if (wr.accel_we) begin
            merged.accel = wr.vec;
         end
         if (wr.gyro_we) begin
            merged.gyro = wr.vec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= merged;
      end
   end

   assign rd = out_ff;

endmodule

// ===== rtl/imufsa_commit.sv =====
module imufsa_commit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  imufsa_pkg::item_type     item,
   input  imufsa_pkg::slot_rd_type  rd,
   input  logic [63:0]              host_time_base,
   output imufsa_pkg::slot_wr_type  wr,
   output logic                     res_vld,
   output imufsa_pkg::sample_type   res
);
   import imufsa_pkg::*;

   logic [SLOT_COUNT-1:0] aseen_ff, aseen_in, gseen_ff, gseen_in;
   logic [SLOT_COUNT-1:0] tvld_ff, tvld_in, avld_ff, avld_in, gvld_ff, gvld_in;
   logic [63:0]           last_ff, last_in;
   logic                  eib_ff, eib_in;

   logic                  clr;
   logic [SLOT_COUNT-1:0] aseen_b, gseen_b, tvld_b, avld_b, gvld_b;
   logic                  eib_b;
   slot_type              s;
   logic [63:0]           t_stored, new_time;
   vec_type               a_stored, g_stored;
   logic                  emit_try;

   assign clr = item.vld && item.batch;
   assign s   = item.slot;

   // state as left by a batch start
   assign aseen_b = clr ? '0 : aseen_ff;
   assign gseen_b = clr ? '0 : gseen_ff;
   assign tvld_b  = clr ? '0 : tvld_ff;
   assign avld_b  = clr ? '0 : avld_ff;
   assign gvld_b  = clr ? '0 : gvld_ff;
   assign eib_b   = clr ? 1'b0 : eib_ff;

   // entries not written since the last clear read as zero
   assign t_stored = tvld_b[s] ? rd.tstamp : '0;
   assign a_stored = avld_b[s] ? rd.accel  : '0;
   assign g_stored = gvld_b[s] ? rd.gyro   : '0;

   assign new_time = host_time_base + {{(64 - PROD_W + Q_SHIFT){1'b0}}, item.prod[PROD_W-1:Q_SHIFT]};

   always_comb begin
      aseen_in = aseen_b;
      gseen_in = gseen_b;
      tvld_in  = tvld_b;
      avld_in  = avld_b;
      gvld_in  = gvld_b;
      eib_in   = eib_b;
      last_in  = last_ff;
      emit_try = 1'b0;
      res_vld  = 1'b0;
      wr          = '0;
      wr.slot     = s;
      wr.tstamp   = new_time;
      wr.vec      = item.vec;
      res.tstamp  = t_stored;
      res.accel   = a_stored;
      res.gyro    = g_stored;
      if (item.vld) begin
         unique case (item.kind)
            KIND_GYRO: begin
               wr.gyro_we  = 1'b1;
               gvld_in[s]  = 1'b1;
               res.gyro    = item.vec;
               emit_try    = aseen_b[s];
               gseen_in[s] = !aseen_b[s];
               aseen_in[s] = 1'b0;
            end
            KIND_ACCEL: begin
               wr.accel_we = 1'b1;
               avld_in[s]  = 1'b1;
               res.accel   = item.vec;
               emit_try    = gseen_b[s];
               aseen_in[s] = !gseen_b[s];
               gseen_in[s] = 1'b0;
            end
            KIND_TIME: begin
               wr.time_we  = 1'b1;
               tvld_in[s]  = 1'b1;
               aseen_in[s] = 1'b0;
               gseen_in[s] = 1'b0;
            end
            KIND_NONE: begin
            end
            default: begin
            end
         endcase
      end
      // drop zero times and repeats of the last time in this batch
      if (emit_try && (t_stored != '0) && !(eib_b && (t_stored == last_ff))) begin
         res_vld = 1'b1;
         last_in = t_stored;
         eib_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aseen_ff <= '0;
         gseen_ff <= '0;
         tvld_ff  <= '0;
         avld_ff  <= '0;
         gvld_ff  <= '0;
         eib_ff   <= 1'b0;
         last_ff  <= '0;
      end else if (adv) begin
         aseen_ff <= aseen_in;
         gseen_ff <= gseen_in;
         tvld_ff  <= tvld_in;
         avld_ff  <= avld_in;
         gvld_ff  <= gvld_in;
         eib_ff   <= eib_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ===== rtl/imufsa_rsp_queue.sv =====
module imufsa_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  imufsa_pkg::sample_type  push_data,
   input  logic                    pop_stall,
   output logic                    head_valid,
   output imufsa_pkg::sample_type  head,
   output logic                    full
);
   import imufsa_pkg::*;

   sample_type          q_mem [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                pop;

   assign head_valid = (cnt_ff != '0);
   assign full       = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign pop        = head_valid && !pop_stall;
   assign head       = q_mem[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// ===== rtl/imu_fifo_sample_assembler_core.sv =====
// channel   direction  handshake          payload
// req       in         req_valid/stall    batch start, tag byte, three data words
// rsp       out        rsp_valid/stall    sample time, accel xyz, gyro xyz
// csr       in         csr_we             register index, 64-bit write data
//
// one FIFO word per cycle while req_stall is low; each accepted word passes through the
// slot read, the multiply and the commit stage, whose samples go into the result queue
// synchronous active-high reset clears control state and the registers; no clearing pass
// a two-entry result queue lets the pipeline keep taking words while a sample waits;
// req_stall is high while that queue is full, which only a stalled response side causes,
// and drops right after the edge at which the head transfer frees an entry
module imu_fifo_sample_assembler_core (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_batch_start,
   input  logic [7:0]                        req_tag_byte,
   input  logic [15:0]                       req_word_x,
   input  logic [15:0]                       req_word_y,
   input  logic [15:0]                       req_word_z,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [63:0]                       rsp_sample_time,
   output logic signed [31:0]                rsp_accel_x,
   output logic signed [31:0]                rsp_accel_y,
   output logic signed [31:0]                rsp_accel_z,
   output logic signed [31:0]                rsp_gyro_x,
   output logic signed [31:0]                rsp_gyro_y,
   output logic signed [31:0]                rsp_gyro_z,

   input  logic                              csr_we,
   input  logic [imufsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [imufsa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import imufsa_pkg::*;

   // configuration registers
   logic [63:0] host_base_ff;
   logic [31:0] sensor_base_ff;
   logic [23:0] tick_period_ff;
   logic [15:0] accel_gain_ff;
   logic [15:0] gyro_gain_ff;

   // pipeline control: every stage moves together while the queue has room
   logic        adv;
   logic        req_accept;
   logic        q_full;

   item_type    item;
   slot_rd_type slot_rd;
   slot_wr_type slot_wr;
   logic        res_vld;
   sample_type  res;
   sample_type  q_head;

   assign adv        = !q_full;
   assign req_stall  = !adv;
   assign req_accept = req_valid && adv;

   // register writes, bits above each register's width dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         host_base_ff   <= '0;
         sensor_base_ff <= '0;
         tick_period_ff <= TICK_PERIOD_RST;
         accel_gain_ff  <= GAIN_RST;
         gyro_gain_ff   <= GAIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HOST_TIME_BASE:   host_base_ff   <= csr_wdata;
            CSR_SENSOR_TIME_BASE: sensor_base_ff <= csr_wdata[31:0];
            CSR_TICK_PERIOD:      tick_period_ff <= csr_wdata[23:0];
            CSR_ACCEL_GAIN:       accel_gain_ff  <= csr_wdata[15:0];
            CSR_GYRO_GAIN:        gyro_gain_ff   <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // decode, tick delta, scaling and time product
   imufsa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .adv              (adv),
      .accept           (req_accept),
      .batch_start      (req_batch_start),
      .tag_byte         (req_tag_byte),
      .word_x           (req_word_x),
      .word_y           (req_word_y),
      .word_z           (req_word_z),
      .sensor_time_base (sensor_base_ff),
      .tick_period_q16  (tick_period_ff),
      .accel_gain       (accel_gain_ff),
      .gyro_gain        (gyro_gain_ff),
      .item             (item)
   );

   // slot memories, read as the word is taken, forwarded to commit
   imufsa_slot_store u_store (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .rd_slot (req_tag_byte[SLOT_W:1]),
      .wr      (slot_wr),
      .rd      (slot_rd)
   );

   // seen flags, batch clear, emit decision and write-back
   imufsa_commit u_commit (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .item           (item),
      .rd             (slot_rd),
      .host_time_base (host_base_ff),
      .wr             (slot_wr),
      .res_vld        (res_vld),
      .res            (res)
   );

   // result skid queue
   imufsa_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (res_vld && adv),
      .push_data  (res),
      .pop_stall  (rsp_stall),
      .head_valid (rsp_valid),
      .head       (q_head),
      .full       (q_full)
   );

   assign rsp_sample_time = q_head.tstamp;
   assign rsp_accel_x     = $signed(q_head.accel[0]);
   assign rsp_accel_y     = $signed(q_head.accel[1]);
   assign rsp_accel_z     = $signed(q_head.accel[2]);
   assign rsp_gyro_x      = $signed(q_head.gyro[0]);
   assign rsp_gyro_y      = $signed(q_head.gyro[1]);
   assign rsp_gyro_z      = $signed(q_head.gyro[2]);

endmodule

// ===== verif/testbench.sv =====
`default_nettype none

// sample assembler check: each FIFO word accepted on the req side is fed to an
// in-bench copy of the timeslot table, and every sample that copy produces is
// queued and compared, field by field, against the next rsp transfer
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import imufsa_pkg::*;

   localparam int ITEM_TARGET  = 450;
   localparam int IDLE_MAX     = 14;
   // three pipeline stages plus a little slack before touching the registers
   localparam int DRAIN_CYCLES = 8;

   logic                  clock;
   logic                  reset           = 1'b1;

   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic                  req_batch_start = 1'b0;
   logic [7:0]            req_tag_byte    = '0;
   logic [15:0]           req_word_x      = '0;
   logic [15:0]           req_word_y      = '0;
   logic [15:0]           req_word_z      = '0;

   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [63:0]           rsp_sample_time;
   logic signed [31:0]    rsp_accel_x;
   logic signed [31:0]    rsp_accel_y;
   logic signed [31:0]    rsp_accel_z;
   logic signed [31:0]    rsp_gyro_x;
   logic signed [31:0]    rsp_gyro_y;
   logic signed [31:0]    rsp_gyro_z;

   logic                  csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;

   imu_fifo_sample_assembler_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_batch_start (req_batch_start),
      .req_tag_byte    (req_tag_byte),
      .req_word_x      (req_word_x),
      .req_word_y      (req_word_y),
      .req_word_z      (req_word_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_time (rsp_sample_time),
      .rsp_accel_x     (rsp_accel_x),
      .rsp_accel_y     (rsp_accel_y),
      .rsp_accel_z     (rsp_accel_z),
      .rsp_gyro_x      (rsp_gyro_x),
      .rsp_gyro_y      (rsp_gyro_y),
      .rsp_gyro_z      (rsp_gyro_z),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // register mirror, reset values
   logic [63:0] cfg_host_base   = 64'd0;
   logic [31:0] cfg_sensor_base = 32'd0;
   logic [23:0] cfg_tick_period = TICK_PERIOD_RST;
   logic [15:0] cfg_accel_gain  = GAIN_RST;
   logic [15:0] cfg_gyro_gain   = GAIN_RST;

   // mirror of the timeslot table
   logic [63:0] slot_stamp      [SLOT_COUNT];
   vec_type     slot_accel_val  [SLOT_COUNT];
   vec_type     slot_gyro_val   [SLOT_COUNT];
   bit          slot_accel_seen [SLOT_COUNT];
   bit          slot_gyro_seen  [SLOT_COUNT];
   logic [63:0] last_stamp;
   bit          stamp_emitted;

   // samples still owed by the block, oldest first
   sample_type  pending_samples[$];

   int          error_count = 0;
   int          words_sent  = 0;
   bit          quiet       = 1'b0;   // no idling on either side
   bit          req_calm    = 1'b0;   // a stretch without req gaps
   bit          stall_calm  = 1'b0;   // a stretch without rsp stalls
   int          stall_left  = 0;
   logic [31:0] prev_ticks  = 32'd0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #2000000;
      $display("imu_fifo_sample_assembler_core test failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   task automatic clear_slots();
      for (int s = 0; s < SLOT_COUNT; s++) begin
         slot_stamp[s]      = '0;
         slot_accel_val[s]  = '0;
         slot_gyro_val[s]   = '0;
         slot_accel_seen[s] = 1'b0;
         slot_gyro_seen[s]  = 1'b0;
      end
      last_stamp    = '0;
      stamp_emitted = 1'b0;
   endtask

   // signed 16-bit count times unsigned gain, low 32 bits
   function automatic logic [31:0] gained_count(input logic [15:0] w, input logic [15:0] g);
      longint cnt;
      longint prod;
      cnt  = longint'($signed(w));
      prod = cnt * longint'({48'd0, g});
      return prod[31:0];
   endfunction

   // sensor ticks to host microseconds; delta wraps at 32 bits, sum at 64
   function automatic logic [63:0] host_time_of(input logic [31:0] ticks);
      logic [31:0] delta;
      logic [63:0] prod;
      delta = ticks - cfg_sensor_base;
      prod  = {32'd0, delta} * {40'd0, cfg_tick_period};
      return cfg_host_base + (prod >> Q_SHIFT);
   endfunction

   task automatic assemble_word(input bit batch, input logic [7:0] tag,
                                input logic [15:0] wx, input logic [15:0] wy,
                                input logic [15:0] wz);
      logic [4:0] sensor;
      int         s;
      sample_type smp;
      sensor = tag[7:3];
      s      = int'(tag[2:1]);
      if (batch) begin
         clear_slots();
      end
      if (sensor == TAG_TIME) begin
         slot_stamp[s]      = host_time_of({wy, wx});
         slot_accel_seen[s] = 1'b0;
         slot_gyro_seen[s]  = 1'b0;
      end else if (sensor == TAG_GYRO || sensor == TAG_ACCEL) begin
         if (sensor == TAG_GYRO) begin
            slot_gyro_val[s]  = {gained_count(wz, cfg_gyro_gain),
                                 gained_count(wy, cfg_gyro_gain),
                                 gained_count(wx, cfg_gyro_gain)};
            slot_gyro_seen[s] = 1'b1;
         end else begin
            slot_accel_val[s]  = {gained_count(wz, cfg_accel_gain),
                                  gained_count(wy, cfg_accel_gain),
                                  gained_count(wx, cfg_accel_gain)};
            slot_accel_seen[s] = 1'b1;
         end
         if (slot_accel_seen[s] && slot_gyro_seen[s]) begin
            slot_accel_seen[s] = 1'b0;
            slot_gyro_seen[s]  = 1'b0;
            // zero time and a repeat of the last time in this batch are dropped
            if (slot_stamp[s] != 64'd0 &&
                !(stamp_emitted && slot_stamp[s] == last_stamp)) begin
               last_stamp    = slot_stamp[s];
               stamp_emitted = 1'b1;
               smp.tstamp    = slot_stamp[s];
               smp.accel     = slot_accel_val[s];
               smp.gyro      = slot_gyro_val[s];
               pending_samples.push_back(smp);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            $display("%0t ns: unexpected sample, expected none, actual time %h",
                     $time, rsp_sample_time);
            error_count++;
         end else begin
            want = pending_samples.pop_front();
            check_field("sample_time", want.tstamp, rsp_sample_time);
            check_field("accel_x", {32'd0, want.accel[0]}, {32'd0, rsp_accel_x});
            check_field("accel_y", {32'd0, want.accel[1]}, {32'd0, rsp_accel_y});
            check_field("accel_z", {32'd0, want.accel[2]}, {32'd0, rsp_accel_z});
            check_field("gyro_x", {32'd0, want.gyro[0]}, {32'd0, rsp_gyro_x});
            check_field("gyro_y", {32'd0, want.gyro[1]}, {32'd0, rsp_gyro_y});
            check_field("gyro_z", {32'd0, want.gyro[2]}, {32'd0, rsp_gyro_z});
         end
      end
   end

   // rsp side back-pressure in bursts, with calm stretches in between
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) begin
         stall_calm = !stall_calm;
      end
      if (reset || quiet) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!stall_calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, IDLE_MAX - 1);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic [7:0] make_tag(input logic [4:0] sensor, input logic [1:0] slot);
      logic spare;
      spare = 1'($urandom_range(0, 1));
      return {sensor, slot, spare};
   endfunction

   // random counts half the time, the extremes otherwise
   function automatic logic [15:0] pick_count();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // one req transfer; valid is left high so back-to-back words need no extra edge
   task automatic send_word(input bit batch, input logic [7:0] tag,
                            input logic [15:0] wx, input logic [15:0] wy,
                            input logic [15:0] wz);
      int gap;
      if (!quiet && !req_calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, IDLE_MAX);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if ($urandom_range(0, 39) == 0) begin
         req_calm = !req_calm;
      end
      req_valid       <= 1'b1;
      req_batch_start <= batch;
      req_tag_byte    <= tag;
      req_word_x      <= wx;
      req_word_y      <= wy;
      req_word_z      <= wz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      assemble_word(batch, tag, wx, wy, wz);
      words_sent++;
   endtask

   // let every owed sample arrive, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_HOST_TIME_BASE:   cfg_host_base   = data;
         CSR_SENSOR_TIME_BASE: cfg_sensor_base = data[31:0];
         CSR_TICK_PERIOD:      cfg_tick_period = data[23:0];
         CSR_ACCEL_GAIN:       cfg_accel_gain  = data[15:0];
         CSR_GYRO_GAIN:        cfg_gyro_gain   = data[15:0];
         default: ;
      endcase
   endtask

   // all five registers, with junk above the width of each register narrower than 64 bits
   task automatic write_config(input logic [63:0] host, input logic [31:0] sensor,
                               input logic [23:0] period, input logic [15:0] again,
                               input logic [15:0] ggain);
      logic [63:0] junk;
      junk = {$urandom(), $urandom()};
      write_reg(CSR_HOST_TIME_BASE, host);
      write_reg(CSR_SENSOR_TIME_BASE, {junk[63:32], sensor});
      write_reg(CSR_TICK_PERIOD, {junk[63:24], period});
      write_reg(CSR_ACCEL_GAIN, {junk[63:16], again});
      write_reg(CSR_GYRO_GAIN, {junk[63:16], ggain});
      csr_we <= 1'b0;
   endtask

   task automatic random_config();
      write_config({$urandom(), $urandom()} | 64'd1, $urandom(),
                   ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                               : 24'($urandom_range(1, 24'h3FFFFF)),
                   16'($urandom), 16'($urandom));
   endtask

   // a group: usually a time word first, then accel and gyro in either order
   task automatic send_sample_group();
      logic [1:0]  slot;
      bit          batch;
      logic [31:0] ticks;
      bit          accel_first;
      slot        = 2'($urandom_range(0, SLOT_COUNT - 1));
      batch       = ($urandom_range(0, 11) == 0);
      accel_first = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 7) != 0) begin
         // repeated ticks give repeated times, which must be dropped
         ticks      = ($urandom_range(0, 5) == 0) ? prev_ticks : $urandom();
         prev_ticks = ticks;
         send_word(batch, make_tag(TAG_TIME, slot), ticks[15:0], ticks[31:16],
                   16'($urandom));
         batch = 1'b0;
      end
      if (accel_first) begin
         send_word(batch, make_tag(TAG_ACCEL, slot), pick_count(), pick_count(), pick_count());
         send_word(1'b0, make_tag(TAG_GYRO, slot), pick_count(), pick_count(), pick_count());
      end else begin
         send_word(batch, make_tag(TAG_GYRO, slot), pick_count(), pick_count(), pick_count());
         send_word(1'b0, make_tag(TAG_ACCEL, slot), pick_count(), pick_count(), pick_count());
      end
   endtask

   // random traffic: mostly groups, the rest stray words with any tag
   task automatic run_traffic(input int n_items);
      int stop_at;
      stop_at = words_sent + n_items;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 3) != 0) begin
            send_sample_group();
         end else begin
            send_word($urandom_range(0, 15) == 0, 8'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset register values: 25 us per tick, unit gains
   task automatic test_reset_defaults();
      send_word(1'b0, make_tag(TAG_TIME, 2'd0), 16'h0000, 16'h0001, 16'hFFFF);
      send_word(1'b0, make_tag(TAG_ACCEL, 2'd0), 16'h7FFF, 16'h8000, 16'hFFFF);
      send_word(1'b0, make_tag(TAG_GYRO, 2'd0), 16'h0001, 16'h0000, 16'h8000);
      drain();
   endtask

   task automatic test_special_words();
      // unknown sensor tags are ignored
      send_word(1'b0, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(1'b0, 8'hFF, 16'h1234, 16'h5678, 16'h9ABC);
      // batch start still clears on an ignored word
      send_word(1'b1, make_tag(5'h03, 2'd1), 16'h0000, 16'h0000, 16'h0000);
      // slot with no time word: zero time, dropped
      send_word(1'b0, make_tag(TAG_ACCEL, 2'd1), 16'h0010, 16'h0020, 16'h0030);
      send_word(1'b0, make_tag(TAG_GYRO, 2'd1), 16'h0040, 16'h0050, 16'h0060);
      // normal sample on slot 2
      send_word(1'b0, make_tag(TAG_TIME, 2'd2), 16'hBEEF, 16'h0042, 16'h0000);
      send_word(1'b0, make_tag(TAG_GYRO, 2'd2), 16'hFFFE, 16'h0002, 16'h7FFF);
      send_word(1'b0, make_tag(TAG_ACCEL, 2'd2), 16'h8001, 16'h0003, 16'h0004);
      // same slot again without a new time word: repeated time, dropped
      send_word(1'b0, make_tag(TAG_ACCEL, 2'd2), 16'h0005, 16'h0006, 16'h0007);
      send_word(1'b0, make_tag(TAG_GYRO, 2'd2), 16'h0008, 16'h0009, 16'h000A);
      // same ticks in another slot: repeated time, dropped
      send_word(1'b0, make_tag(TAG_TIME, 2'd3), 16'hBEEF, 16'h0042, 16'h5555);
      send_word(1'b0, make_tag(TAG_ACCEL, 2'd3), 16'h0100, 16'h0200, 16'h0300);
      send_word(1'b0, make_tag(TAG_GYRO, 2'd3), 16'h0400, 16'h0500, 16'h0600);
      // time word between partners clears the accel flag
      send_word(1'b0, make_tag(TAG_ACCEL, 2'd1), 16'h1111, 16'h2222, 16'h3333);
      send_word(1'b0, make_tag(TAG_TIME, 2'd1), 16'h0001, 16'h0000, 16'h0000);
      send_word(1'b0, make_tag(TAG_GYRO, 2'd1), 16'h4444, 16'h5555, 16'h6666);
      send_word(1'b0, make_tag(TAG_ACCEL, 2'd1), 16'h7777, 16'h8888, 16'h9999);
      // new batch: the earlier time is allowed once more
      send_word(1'b1, make_tag(TAG_TIME, 2'd2), 16'hBEEF, 16'h0042, 16'h0000);
      send_word(1'b0, make_tag(TAG_ACCEL, 2'd2), 16'hAAAA, 16'hBBBB, 16'hCCCC);
      send_word(1'b0, make_tag(TAG_GYRO, 2'd2), 16'hDDDD, 16'hEEEE, 16'hFFFF);
      drain();
   endtask

   // largest bases, period and gains: tick delta and host time both wrap
   task automatic test_register_extremes();
      write_config(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_word(1'b1, make_tag(TAG_TIME, 2'd0), 16'h0000, 16'h0000, 16'h0000);
      send_word(1'b0, make_tag(TAG_GYRO, 2'd0), 16'h7FFF, 16'h8000, 16'hFFFF);
      send_word(1'b0, make_tag(TAG_ACCEL, 2'd0), 16'h8000, 16'h7FFF, 16'h0001);
      send_word(1'b0, make_tag(TAG_TIME, 2'd3), 16'hFFFE, 16'hFFFF, 16'h0000);
      send_word(1'b0, make_tag(TAG_ACCEL, 2'd3), 16'hFFFF, 16'h0000, 16'h8000);
      send_word(1'b0, make_tag(TAG_GYRO, 2'd3), 16'h0000, 16'hFFFF, 16'h7FFF);
      drain();
   endtask

   task automatic test_random_settings();
      random_config();
      run_traffic(120);
      drain();
      // zero period and gains: every time equals the host base, most are repeats
      write_config(64'd1, 32'd0, 24'd0, 16'd0, 16'd0);
      run_traffic(40);
      drain();
      write_config({$urandom(), $urandom()}, $urandom(), 24'hFF_FFFF, 16'hFFFF, 16'd1);
      run_traffic(100);
      drain();
      random_config();
      run_traffic(90);
      drain();
   endtask

   // last part: full rate on both sides
   task automatic test_back_to_back();
      quiet = 1'b1;
      random_config();
      run_traffic(ITEM_TARGET - 380);
      drain();
   endtask

   initial begin
      clear_slots();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_special_words();
      test_register_extremes();
      test_random_settings();
      test_back_to_back();
      if (error_count == 0) begin
         $display("imu_fifo_sample_assembler_core test passed");
      end else begin
         $display("imu_fifo_sample_assembler_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/imufsa_pkg.sv
rtl/imufsa_front.sv
rtl/imufsa_slot_store.sv
rtl/imufsa_commit.sv
rtl/imufsa_rsp_queue.sv
rtl/imu_fifo_sample_assembler_core.sv
verif/testbench.sv
